>>> rtl/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg
// Shared types, constants and the arctangent table for the spherical to
// cartesian offset block.
// ----------------------------------------------------------------------------
package s2c_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int IDX_W         = $clog2(TABLE_LEN);

  // CORDIC gain, Q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        radius;
    logic               flip_lon;
    logic               flip_lat;
    rot_t               lon;
    rot_t               lat;
  } item_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340247;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/spherical_to_cartesian_offset.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian_offset
// Point on a sphere around a centre from longitude, latitude and radius.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in      | into      | in_valid_i / in_stall_o | center_x/y/z, longitude,
//         |           |                         | latitude, radius
// out     | out of    | out_valid_o / out_stall_i | point_x/y/z
//
// One item enters per cycle while in_stall_o is low; an item passes 16 CORDIC
// cells, then two multiply stages and the sum/saturate output register.
// The whole pipeline advances as one: it holds only while a finished item
// sits at the output and out_stall_i is high, and bubbles pass through.
// Reset clears the valid bits of all stages; payload registers are not reset.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_offset (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [15:0]        longitude_i,
  input  logic [15:0]        latitude_i,
  input  logic [30:0]        radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o
);

  localparam int N = s2c_pkg::NUM_STAGES;

  logic           en;
  logic           valid_c [N+1];
  s2c_pkg::item_t item_c  [N+1];
  logic [31:0]    a_lon, a_lat;
  logic           flip_lon, flip_lat;

  // advance unless the output holds an item that is not taken
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // widen angles to a 32-bit turn fraction, fold into [-1/4, 1/4)
  assign a_lon    = {longitude_i[s2c_pkg::ANGLE_BITS-1:0], {(32-s2c_pkg::ANGLE_BITS){1'b0}}};
  assign a_lat    = {latitude_i[s2c_pkg::ANGLE_BITS-1:0], {(32-s2c_pkg::ANGLE_BITS){1'b0}}};
  assign flip_lon = a_lon[31] ^ a_lon[30];
  assign flip_lat = a_lat[31] ^ a_lat[30];

  always_comb begin
    valid_c[0]         = in_valid_i;
    item_c[0].cx       = center_x_i;
    item_c[0].cy       = center_y_i;
    item_c[0].cz       = center_z_i;
    item_c[0].radius   = radius_i;
    item_c[0].flip_lon = flip_lon;
    item_c[0].flip_lat = flip_lat;
    item_c[0].lon.x    = s2c_pkg::CORDIC_GAIN;
    item_c[0].lon.y    = '0;
    item_c[0].lon.z    = 33'($signed({a_lon[31] ^ flip_lon, a_lon[30:0]}));
    item_c[0].lat.x    = s2c_pkg::CORDIC_GAIN;
    item_c[0].lat.y    = '0;
    item_c[0].lat.z    = 33'($signed({a_lat[31] ^ flip_lat, a_lat[30:0]}));
  end

  // row of rotation cells, one per arctangent step
  for (genvar k = 0; k < N; k++) begin : g_cell
    s2c_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (s2c_pkg::IDX_W'(k)),
      .valid_i(valid_c[k]),
      .item_i (item_c[k]),
      .valid_o(valid_c[k+1]),
      .item_o (item_c[k+1])
    );
  end

  s2c_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_c[N]),
    .item_i   (item_c[N]),
    .valid_o  (out_valid_o),
    .point_x_o(point_x_o),
    .point_y_o(point_y_o),
    .point_z_o(point_z_o)
  );

endmodule

>>> rtl/s2c_cell.sv
// ----------------------------------------------------------------------------
// s2c_cell
// One CORDIC rotation step for both angles; passes the item to the next cell.
// ----------------------------------------------------------------------------
module s2c_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [s2c_pkg::IDX_W-1:0] idx_i,
  input  logic                      valid_i,
  input  s2c_pkg::item_t            item_i,
  output logic                      valid_o,
  output s2c_pkg::item_t            item_o
);

  logic           valid_q;
  s2c_pkg::item_t item_q, item_d;
  logic [32:0]    atan;

  function automatic s2c_pkg::rot_t rot_step(input s2c_pkg::rot_t r,
                                             input logic [s2c_pkg::IDX_W-1:0] i,
                                             input logic [32:0] a);
    s2c_pkg::rot_t o;
    logic signed [33:0] dx, dy;
    dx = r.y >>> i;
    dy = r.x >>> i;
    if (!r.z[32]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - $signed(a);
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + $signed(a);
    end
    return o;
  endfunction

  assign atan = {1'b0, s2c_pkg::atan_turn(idx_i)};

  always_comb begin
    item_d     = item_i;
    item_d.lon = rot_step(item_i.lon, idx_i, atan);
    item_d.lat = rot_step(item_i.lat, idx_i, atan);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/s2c_post.sv
// ----------------------------------------------------------------------------
// s2c_post
// Scale sine and cosine by the radius, add the centre and saturate.
// ----------------------------------------------------------------------------
module s2c_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  s2c_pkg::item_t     item_i,
  output logic               valid_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o
);

  // stage 1: r*cos(lat), r*sin(lat)
  logic signed [31:0] slon, clon, slat, clat;
  logic signed [31:0] r_s;
  logic signed [63:0] p_rcl, p_ry;
  logic signed [33:0] rcl_d, ry_d;

  logic               v1_q;
  logic signed [33:0] rcl_q, ry_q;
  logic signed [31:0] slon_q, clon_q, cx1_q, cy1_q, cz1_q;

  // stage 2: rcl*cos(lon), rcl*sin(lon)
  logic signed [65:0] p_x, p_z;
  logic signed [35:0] mx_d, mz_d;

  logic               v2_q;
  logic signed [35:0] mx_q, mz_q;
  logic signed [33:0] ry2_q;
  logic signed [31:0] cx2_q, cy2_q, cz2_q;

  // stage 3: sum and saturate
  logic signed [36:0] sx, sy, sz;
  logic               v3_q;
  logic signed [31:0] px_q, py_q, pz_q;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647)       return 32'sh7FFFFFFF;
    else if (v < -37'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  always_comb begin
    slon = item_i.flip_lon ? 32'(-item_i.lon.y) : item_i.lon.y[31:0];
    clon = item_i.flip_lon ? 32'(-item_i.lon.x) : item_i.lon.x[31:0];
    slat = item_i.flip_lat ? 32'(-item_i.lat.y) : item_i.lat.y[31:0];
    clat = item_i.flip_lat ? 32'(-item_i.lat.x) : item_i.lat.x[31:0];
    r_s   = $signed({1'b0, item_i.radius});
    p_rcl = r_s * clat;
    p_ry  = r_s * slat;
    rcl_d = 34'((p_rcl + 64'sd536870912) >>> 30);
    ry_d  = 34'((p_ry + 64'sd536870912) >>> 30);
  end

  always_comb begin
    p_x  = 66'(rcl_q) * 66'(clon_q);
    p_z  = 66'(rcl_q) * 66'(slon_q);
    mx_d = 36'((p_x + 66'sd536870912) >>> 30);
    mz_d = 36'((p_z + 66'sd536870912) >>> 30);
    sx   = 37'(cx2_q) - 37'(mx_q);
    sy   = 37'(cy2_q) + 37'(ry2_q);
    sz   = 37'(cz2_q) + 37'(mz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rcl_q  <= rcl_d;
      ry_q   <= ry_d;
      slon_q <= slon;
      clon_q <= clon;
      cx1_q  <= item_i.cx;
      cy1_q  <= item_i.cy;
      cz1_q  <= item_i.cz;
      mx_q   <= mx_d;
      mz_q   <= mz_d;
      ry2_q  <= ry_q;
      cx2_q  <= cx1_q;
      cy2_q  <= cy1_q;
      cz2_q  <= cz1_q;
      px_q   <= sat32(sx);
      py_q   <= sat32(sy);
      pz_q   <= sat32(sz);
    end
  end

  assign valid_o   = v3_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign point_z_o = pz_q;

endmodule

>>> tb/sv/s2c_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// s2c_checker
// Watches both channels of the spherical to cartesian offset block, predicts
// each point from the accepted item and compares it with the returned one.
// ----------------------------------------------------------------------------
module s2c_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [15:0]        longitude_i,
  input  logic [15:0]        latitude_i,
  input  logic [30:0]        radius_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  point_t points_due[$];

  localparam longint ATAN_TURNS [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340247, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  // Rotation-mode CORDIC on a turn fraction, with half-turn folding.
  task automatic turn_sincos(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, dx, dy;
    a = 32'(ang[s2c_pkg::ANGLE_BITS-1:0]) << (32 - s2c_pkg::ANGLE_BITS);
    flip = (a >= 32'h4000_0000) && (a < 32'hC000_0000);
    if (flip) a ^= 32'h8000_0000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < s2c_pkg::NUM_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint scale_q30(longint len, longint trig);
    return (len * trig + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  assign pending_o = points_due.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    longint slon, clon, slat, clat, r, rcl;
    point_t p, e;
    int     errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
      points_due.delete();
    end else begin
      errs = 0;
      if (in_valid_i && !in_stall_i) begin
        turn_sincos(longitude_i, slon, clon);
        turn_sincos(latitude_i, slat, clat);
        r = longint'(radius_i);
        rcl = scale_q30(r, clat);
        p.x = clamp32(longint'(center_x_i) - scale_q30(rcl, clon));
        p.y = clamp32(longint'(center_y_i) + scale_q30(r, slat));
        p.z = clamp32(longint'(center_z_i) + scale_q30(rcl, slon));
        points_due.push_back(p);
      end
      if (out_valid_i && !out_stall_i) begin
        if (points_due.size() == 0) begin
          $error("point returned with none expected");
          errs++;
        end else begin
          e = points_due.pop_front();
          if (point_x_i !== e.x) begin
            $error("point_x expected %0d got %0d", e.x, point_x_i);
            errs++;
          end
          if (point_y_i !== e.y) begin
            $error("point_y expected %0d got %0d", e.y, point_y_i);
            errs++;
          end
          if (point_z_i !== e.z) begin
            $error("point_z expected %0d got %0d", e.z, point_z_i);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random points through the spherical to cartesian
// offset block with random gaps and stalls; a checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = s2c_pkg::NUM_STAGES + 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] center_x_i = '0;
  logic signed [31:0] center_y_i = '0;
  logic signed [31:0] center_z_i = '0;
  logic [15:0]        longitude_i = '0;
  logic [15:0]        latitude_i = '0;
  logic [30:0]        radius_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] point_x_o, point_y_o, point_z_o;
  int                 fail_count, pending;
  int                 idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  spherical_to_cartesian_offset dut (.*);

  s2c_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .center_x_i, .center_y_i, .center_z_i, .longitude_i, .latitude_i, .radius_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .point_x_i(point_x_o), .point_y_i(point_y_o), .point_z_i(point_z_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stall the output side for a random number of cycles per point.
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      out_stall_i <= (wait_n != 0);
      repeat (wait_n) @(posedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Present one item, hold it until accepted, then drop valid only if a gap follows.
  task automatic send_point(input logic [31:0] cx, cy, cz, input logic [15:0] lon, lat,
                            input logic [30:0] r);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    center_x_i  <= cx;
    center_y_i  <= cy;
    center_z_i  <= cz;
    longitude_i <= lon;
    latitude_i  <= lat;
    radius_i    <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fff_ffff} ^ $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [15:0] corners [8];
    corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                16'h3FFF, 16'hBFFF, 16'hFFFF, 16'h2000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: quadrant boundaries of each angle, saturation at both ends, then a zero radius and a mixed pattern.
    foreach (corners[i])
      send_point(32'd0, 32'd0, 32'd0, corners[i], corners[7 - i], 31'h0001_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h8000, 16'h4000, 31'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'hC000, 31'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h4000, 16'h0000, 31'h7fff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hC000, 16'h8000, 31'h7fff_ffff);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h1234_5678, 16'h1111, 16'hEEEE, 31'h0);
    send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 16'h5555, 16'hAAAA, 31'h5555_5555);

    // Hold off until the pipeline has returned every point.
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_point(pick_len(), pick_len(), pick_len(), 16'($urandom), 16'($urandom),
                 31'(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'h0010_0000)));
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
